// ===== src/acwr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwr_pkg
// Shared types and constants of the associative cache with replacement:
// payload structs, configuration codes and controller/datapath signals.
// ----------------------------------------------------------------------------
package acwr_pkg;

	// Fixed field widths
	localparam int REQ_W      = 16;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 32;
	localparam int LFSR_W     = 16;
	localparam int CAP_CFG_W  = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [LFSR_W-1:0]    LFSR_MASK     = 16'hB400;
	localparam logic [LFSR_W-1:0]    LFSR_SEED     = 16'h0001;
	localparam logic [CAP_CFG_W-1:0] CAP_CFG_RESET = 5'd16;
	localparam logic [CNT_W-1:0]     CNT_MAX       = 32'hFFFF_FFFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_CAPACITY = 8'd1;

	// Replacement modes
	typedef enum logic [1:0] {
		RM_RANDOM = 2'd0,
		RM_LIFO   = 2'd1,
		RM_FIFO   = 2'd2,
		RM_ZERO   = 2'd3
	} replace_mode_t;

	// Victim selection for direct picks
	typedef enum logic [1:0] {
		VS_FREE = 2'd0,
		VS_LAST = 2'd1,
		VS_ZERO = 2'd2
	} victim_sel_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_SCAN  = 3'd1,
		ST_MISS  = 3'd2,
		ST_MOD   = 3'd3,
		ST_WRITE = 3'd4,
		ST_DONE  = 3'd5
	} state_t;

	// Input item
	typedef struct packed {
		logic [REQ_W-1:0] request_id;
		logic             backing_found;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic              hit;
		logic              filled;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  total_accesses;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic        load_req;
		logic        scan;
		logic        take_hit;
		logic        pick;
		victim_sel_t sel;
		logic        mod_start;
		logic        mod_src_lfsr;
		logic        mod_take;
		logic        write;
		logic        finish;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic          hit_found;
		logic          scan_miss;
		logic          found;
		logic          room;
		replace_mode_t mode;
		logic          mod_done;
		logic          out_free;
	} dp_stat_t;

endpackage

// ===== src/acwr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module acwr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/acwr_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwr_mod
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per
// cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module acwr_mod #(
	parameter int DW = 16,
	parameter int CW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          busy,
	output logic [CW-1:0] rem
);

	localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    dvd_q;
	logic [CW-1:0]    div_q;
	logic [CW-1:0]    rem_q;
	logic [CW:0]      trial;
	logic [CW:0]      diff;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, div_q};

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder; stays below the divisor so it fits CW bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[CW-1:0];
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// ===== src/acwr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwr_dp
// Datapath: configuration registers, tag RAM scan, victim selection, LFSR,
// FIFO pointer, saturating counters and the result register.
// ----------------------------------------------------------------------------
module acwr_dp import acwr_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int ID_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctrl_cmd_t             cmd,
	output dp_stat_t              stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Saturating increment
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	replace_mode_t        mode_q;
	logic [CAP_CFG_W-1:0] cap_cfg_q;
	logic [CW-1:0]        cap;

	logic [ID_BITS-1:0]   tag_q;
	logic                 found_q;
	logic [CW-1:0]        used_q;
	logic [CW-1:0]        scan_q;
	logic                 cmp_v_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic [AW-1:0]        ptr_q;
	logic [LFSR_W-1:0]    lfsr_q;
	logic [LFSR_W-1:0]    lfsr_nxt;
	logic [AW-1:0]        victim_q;
	logic [CW-1:0]        used_dec;
	logic                 res_hit_q;
	logic                 res_fill_q;
	logic [AW-1:0]        res_idx_q;
	logic [CNT_W-1:0]     acc_q;
	logic [CNT_W-1:0]     hitc_q;
	logic [CNT_W-1:0]     missc_q;
	logic [CNT_W-1:0]     acc_n;
	logic [CNT_W-1:0]     hitc_n;
	logic [CNT_W-1:0]     missc_n;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 rd_en;
	logic [ID_BITS-1:0]   rd_data;
	logic                 mod_busy;
	logic [CW-1:0]        mod_rem;
	logic [CW-1:0]        rem_inc;
	logic [LFSR_W-1:0]    mod_dividend;

	// Effective capacity: zero acts as one, clamp at CAPACITY
	always_comb begin
		if (cap_cfg_q == '0) begin
			cap = CW'(1);
		end else if (32'(cap_cfg_q) > CAPACITY) begin
			cap = CW'(CAPACITY);
		end else begin
			cap = CW'(cap_cfg_q);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= RM_FIFO;
			cap_cfg_q <= CAP_CFG_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_REPLACE_MODE) begin
				mode_q <= replace_mode_t'(cfg_data[1:0]);
			end else if (cfg_index == CFG_CACHE_CAPACITY) begin
				cap_cfg_q <= cfg_data[CAP_CFG_W-1:0];
			end
		end
	end

	// Tag RAM, scanned one entry per cycle
	assign rd_en = cmd.scan && (scan_q < used_q);

	acwr_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (CAPACITY)
	) u_tag_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (victim_q),
		.wdata (tag_q),
		.re    (rd_en),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_data)
	);

	// Galois LFSR step, shifting right
	assign lfsr_nxt = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);

	// Remainder unit for random and FIFO victims
	assign mod_dividend = cmd.mod_src_lfsr ? lfsr_nxt : LFSR_W'(ptr_q);

	acwr_mod #(
		.DW (LFSR_W),
		.CW (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_dividend),
		.divisor  (cap),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	assign rem_inc  = mod_rem + 1'b1;
	assign used_dec = used_q - 1'b1;

	// Control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			scan_q   <= '0;
			cmp_v_s1 <= 1'b0;
			ptr_q    <= '0;
			lfsr_q   <= LFSR_SEED;
		end else begin
			cmp_v_s1 <= rd_en;
			if (cmd.load_req) begin
				scan_q <= '0;
			end else if (rd_en) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.pick && (cmd.sel == VS_FREE)) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.mod_start && cmd.mod_src_lfsr) begin
				lfsr_q <= lfsr_nxt;
			end
			// FIFO pointer moves to victim + 1, wrapping at capacity
			if (cmd.mod_take && (mode_q == RM_FIFO)) begin
				ptr_q <= (rem_inc == cap) ? '0 : rem_inc[AW-1:0];
			end
		end
	end

	// Item payload and per-item result
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q[AW-1:0];
		if (cmd.load_req) begin
			tag_q      <= ID_BITS'(in_data.request_id);
			found_q    <= in_data.backing_found;
			res_hit_q  <= 1'b0;
			res_fill_q <= 1'b0;
			res_idx_q  <= '0;
		end
		if (cmd.take_hit) begin
			res_hit_q <= 1'b1;
			res_idx_q <= cmp_idx_s1;
		end
		if (cmd.pick) begin
			case (cmd.sel)
				VS_FREE: victim_q <= used_q[AW-1:0];
				VS_LAST: victim_q <= used_dec[AW-1:0];
				VS_ZERO: victim_q <= '0;
				default: victim_q <= '0;
			endcase
		end
		if (cmd.mod_take) begin
			victim_q <= mod_rem[AW-1:0];
		end
		if (cmd.write) begin
			res_fill_q <= 1'b1;
			res_idx_q  <= victim_q;
		end
	end

	// Counter updates for the finishing item
	assign acc_n   = sat_inc(acc_q);
	assign hitc_n  = res_hit_q ? sat_inc(hitc_q) : hitc_q;
	assign missc_n = res_hit_q ? missc_q : sat_inc(missc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			hitc_q      <= '0;
			missc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				acc_q       <= acc_n;
				hitc_q      <= hitc_n;
				missc_q     <= missc_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.hit            <= res_hit_q;
			out_q.filled         <= res_fill_q;
			out_q.slot           <= SLOT_W'(res_idx_q);
			out_q.total_accesses <= acc_n;
			out_q.hit_count      <= hitc_n;
			out_q.miss_count     <= missc_n;
		end
	end

	// Status to the controller
	always_comb begin
		stat.hit_found = cmp_v_s1 && (rd_data == tag_q);
		stat.scan_miss = !cmp_v_s1 && (scan_q >= used_q);
		stat.found     = found_q;
		stat.room      = used_q < cap;
		stat.mode      = mode_q;
		stat.mod_done  = !mod_busy;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/acwr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwr_ctrl
// Controller: sequences lookup, miss handling, victim choice, tag write and
// result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module acwr_ctrl import acwr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit_found) begin
					cmd.take_hit = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
					if (stat.scan_miss) begin
						state_d = ST_MISS;
					end
				end
			end
			ST_MISS: begin
				if (!stat.found) begin
					state_d = ST_DONE;
				end else if (stat.room) begin
					cmd.pick = 1'b1;
					cmd.sel  = VS_FREE;
					state_d  = ST_WRITE;
				end else begin
					case (stat.mode)
						RM_RANDOM: begin
							cmd.mod_start    = 1'b1;
							cmd.mod_src_lfsr = 1'b1;
							state_d          = ST_MOD;
						end
						RM_FIFO: begin
							cmd.mod_start = 1'b1;
							state_d       = ST_MOD;
						end
						RM_LIFO: begin
							cmd.pick = 1'b1;
							cmd.sel  = VS_LAST;
							state_d  = ST_WRITE;
						end
						default: begin
							cmd.pick = 1'b1;
							cmd.sel  = VS_ZERO;
							state_d  = ST_WRITE;
						end
					endcase
				end
			end
			ST_MOD: begin
				if (stat.mod_done) begin
					cmd.mod_take = 1'b1;
					state_d      = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/assoc_cache_with_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_cache_with_replacement
// Fully associative tag cache with random, LIFO, FIFO or slot-zero
// replacement and saturating access, hit and miss counters.
// ----------------------------------------------------------------------------
// One item is handled at a time. The tags sit in a single-port-read RAM that
// is searched one slot per cycle, so a hit is found when its slot is read
// and a miss once every used slot is read; a filled item adds the tag
// write. Replacing in random or FIFO mode also waits for the bit-serial
// remainder unit that reduces the LFSR value or the pointer modulo the
// capacity. A new item is accepted while the previous result still waits
// in the output register. There is no clearing pass after reset.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module assoc_cache_with_replacement import acwr_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int ID_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	acwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acwr_dp #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Every access is either a hit or a miss until the access count saturates
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.total_accesses != CNT_MAX)) |->
		({1'b0, out_data.total_accesses} ==
		 ({1'b0, out_data.hit_count} + {1'b0, out_data.miss_count})))
		else $error("access count differs from hits plus misses");

	// A filled slot only comes from a miss
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.filled) |-> !out_data.hit)
		else $error("result both hit and filled");

	// Finishing an item presents a result
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished item not presented");

	// One item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in flight");

endmodule
